@@ design/qed_pkg.sv @@
// Shared types, codes and the phase transition table for the quadrature decoder.
package qed_pkg;

  localparam int unsigned TS_W = 32;

  typedef enum logic [2:0] {
    PH_REST = 3'd0,
    PH_CW1  = 3'd1,
    PH_CW2  = 3'd2,
    PH_CW3  = 3'd3,
    PH_CCW1 = 3'd4,
    PH_CCW2 = 3'd5,
    PH_CCW3 = 3'd6,
    PH_AMBIG = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_UNCHANGED = 2'd1,
    FLT_SKIPPED   = 2'd2,
    FLT_AMBIGUOUS = 2'd3
  } fault_t;

  // Pin pair codes: bit 0 is pin A, bit 1 is pin B.
  localparam logic [1:0] PINS_LOW  = 2'd0;
  localparam logic [1:0] PINS_A    = 2'd1;
  localparam logic [1:0] PINS_B    = 2'd2;
  localparam logic [1:0] PINS_HIGH = 2'd3;

  typedef struct packed {
    phase_t next;
    fault_t fault;
    logic   cw;
    logic   ccw;
  } move_t;

  function automatic move_t mk(phase_t nxt, fault_t flt, logic cw, logic ccw);
    move_t m;
    m.next  = nxt;
    m.fault = flt;
    m.cw    = cw;
    m.ccw   = ccw;
    return m;
  endfunction

  function automatic move_t phase_move(phase_t cur, logic [1:0] pins);
    move_t m;
    m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
    case (cur)
      PH_REST: begin
        case (pins)
          PINS_LOW:  m = mk(PH_AMBIG, FLT_AMBIGUOUS, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CW1, FLT_NONE, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CCW1, FLT_NONE, 1'b0, 1'b0);
          default:   m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
        endcase
      end
      PH_CW1: begin
        case (pins)
          PINS_LOW:  m = mk(PH_CW2, FLT_NONE, 1'b0, 1'b0);
          PINS_A:    m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CW3, FLT_SKIPPED, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_NONE, 1'b0, 1'b0);
        endcase
      end
      PH_CW2: begin
        case (pins)
          PINS_LOW:  m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CW1, FLT_NONE, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CW3, FLT_NONE, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_SKIPPED, 1'b1, 1'b0);
        endcase
      end
      PH_CW3: begin
        case (pins)
          PINS_LOW:  m = mk(PH_CW2, FLT_NONE, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CW1, FLT_SKIPPED, 1'b0, 1'b0);
          PINS_B:    m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_NONE, 1'b1, 1'b0);
        endcase
      end
      PH_CCW1: begin
        case (pins)
          PINS_LOW:  m = mk(PH_CCW2, FLT_NONE, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CCW3, FLT_SKIPPED, 1'b0, 1'b0);
          PINS_B:    m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_NONE, 1'b0, 1'b0);
        endcase
      end
      PH_CCW2: begin
        case (pins)
          PINS_LOW:  m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CCW3, FLT_NONE, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CCW1, FLT_NONE, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_SKIPPED, 1'b0, 1'b1);
        endcase
      end
      PH_CCW3: begin
        case (pins)
          PINS_LOW:  m = mk(PH_CCW2, FLT_NONE, 1'b0, 1'b0);
          PINS_A:    m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CCW1, FLT_SKIPPED, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_NONE, 1'b0, 1'b1);
        endcase
      end
      default: begin
        case (pins)
          PINS_LOW:  m = mk(cur, FLT_UNCHANGED, 1'b0, 1'b0);
          PINS_A:    m = mk(PH_CCW3, FLT_NONE, 1'b0, 1'b0);
          PINS_B:    m = mk(PH_CW3, FLT_NONE, 1'b0, 1'b0);
          default:   m = mk(PH_REST, FLT_AMBIGUOUS, 1'b0, 1'b0);
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

@@ design/qed_phase_fsm.sv @@
// Phase state register of the quadrature decoder and its transition lookup.
module qed_phase_fsm (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [1:0]      pins,
  output qed_pkg::move_t  move
);

  qed_pkg::phase_t phase;

  always_comb begin
    move = qed_pkg::phase_move(phase, pins);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qed_pkg::PH_REST;
    end else if (advance) begin
      phase <= move.next;
    end
  end

endmodule

@@ design/qed_press.sv @@
// Push button edge detector with a minimum spacing between counted presses.
module qed_press #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      push_level,
  input  logic [qed_pkg::TS_W-1:0]  time_now,
  input  logic [qed_pkg::TS_W-1:0]  debounce_ticks,
  output logic                      press
);

  localparam int unsigned CMP_W = (TIME_BITS > qed_pkg::TS_W) ? TIME_BITS : qed_pkg::TS_W;

  logic                 push_was_high;
  logic [TIME_BITS-1:0] last_push_time;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] diff;
  logic                 rise;

  always_comb begin
    now  = TIME_BITS'(time_now);
    // Wrapping difference, modulo the timestamp width.
    diff = now - last_push_time;
    rise = push_level && !push_was_high;
    press = rise && (CMP_W'(diff) > CMP_W'(debounce_ticks));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_was_high  <= 1'b0;
      last_push_time <= '0;
    end else if (advance) begin
      push_was_high <= push_level;
      if (rise) begin
        last_push_time <= now;
      end
    end
  end

endmodule

@@ design/quadrature_encoder_decoder.sv @@
// Quadrature encoder decoder top level: handshakes, result register, configuration register.
//
// Usage: each input request carries one sample of the encoder pins (quad_pins), the
// push switch level and a free-running timestamp. Every accepted sample produces
// exactly one result: clockwise or counter-clockwise detent flags, a debounced press
// flag, a fault code and the phase reached.
// The result appears on the out channel in the cycle after the input is accepted; with
// the receiver ready the block takes one sample every cycle. All decoding is one
// table lookup plus one timestamp subtraction and compare, done between the input
// ports and the result register.
// When the receiver stalls, the result is held and in_ready drops until the result
// is taken; in the cycle it is taken a new sample can be accepted again.
// The cfg channel writes debounce_ticks, which the tick gap between push rising edges must
// exceed for a press to count; it is always ready and should be written while idle.
// Reset (rst, synchronous) returns the phase to rest, clears the push history and
// last edge time, sets debounce_ticks to zero and empties the result register.
module quadrature_encoder_decoder #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                quad_pins,
  input  logic                      push_level,
  input  logic [qed_pkg::TS_W-1:0]  time_now,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      step_cw,
  output logic                      step_ccw,
  output logic                      press,
  output logic [1:0]                fault,
  output logic [2:0]                phase_now,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [qed_pkg::TS_W-1:0]  cfg_data
);

  logic                      in_fire;
  logic [qed_pkg::TS_W-1:0]  debounce_ticks;
  qed_pkg::move_t            move;
  logic                      press_next;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  qed_phase_fsm u_phase (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .pins    (quad_pins),
    .move    (move)
  );

  qed_press #(
    .TIME_BITS (TIME_BITS)
  ) u_press (
    .clk            (clk),
    .rst            (rst),
    .advance        (in_fire),
    .push_level     (push_level),
    .time_now       (time_now),
    .debounce_ticks (debounce_ticks),
    .press          (press_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      debounce_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_cw   <= move.cw;
      step_ccw  <= move.ccw;
      press     <= press_next;
      fault     <= move.fault;
      phase_now <= move.next;
    end
  end

  // A detent can only be reported in one direction at a time.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(step_cw && step_ccw))
    else $error("both detent directions reported");

  // A completed detent always lands in the rest phase.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (step_cw || step_ccw)) |-> (phase_now == qed_pkg::PH_REST))
    else $error("detent reported away from rest");

  // An ambiguous fault either enters the ambiguous phase or leaves it to rest.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault == qed_pkg::FLT_AMBIGUOUS) |->
      (phase_now == qed_pkg::PH_AMBIG || phase_now == qed_pkg::PH_REST))
    else $error("ambiguous fault with unexpected phase");

  // Every accepted request yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

endmodule
